// ===== hw/rtl/jetp_pkg.sv =====
// ----------------------------------------------------------------------------
// jetp_pkg
// Shared types, constants, palette and saturation helper for the Julia
// escape-time pixel evaluator.
// ----------------------------------------------------------------------------
package jetp_pkg;

  localparam int COORD_BITS_DEF = 11;
  localparam int ITER_BITS_DEF  = 10;

  localparam int WORD_BITS       = 32;
  localparam int FRAC_BITS       = 28;
  localparam int PROD_BITS       = 2 * WORD_BITS;
  localparam int PALETTE_ENTRIES = 27;
  localparam int LAYER_BITS      = 5;
  localparam int LAYER_MAX       = PALETTE_ENTRIES - 1;
  localparam int CFG_IDX_BITS    = 3;

  // |z|^2 >= 4.0 in Q8.56
  localparam logic [PROD_BITS:0] ESC_LIMIT = (PROD_BITS + 1)'(1) << (2 * FRAC_BITS + 2);

  localparam logic signed [WORD_BITS-1:0] LEFT_ORIGIN_RST = -32'sd536870912;
  localparam logic signed [WORD_BITS-1:0] TOP_ORIGIN_RST  = -32'sd268435456;
  localparam logic signed [WORD_BITS-1:0] X_STEP_RST      = 32'sd1258291;
  localparam logic signed [WORD_BITS-1:0] Y_STEP_RST      = 32'sd1118481;
  localparam logic signed [WORD_BITS-1:0] C_REAL_RST      = -32'sd214748365;
  localparam logic signed [WORD_BITS-1:0] C_IMAG_RST      = 32'sd41875931;
  localparam int ITER_LIMIT_RST = 500;
  localparam int LAYER_SPAN_RST = 18;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_LEFT_ORIGIN = 3'd0,
    REG_TOP_ORIGIN  = 3'd1,
    REG_X_STEP      = 3'd2,
    REG_Y_STEP      = 3'd3,
    REG_C_REAL      = 3'd4,
    REG_C_IMAG      = 3'd5,
    REG_ITER_LIMIT  = 3'd6,
    REG_LAYER_SPAN  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] left_origin;
    logic signed [WORD_BITS-1:0] top_origin;
    logic signed [WORD_BITS-1:0] x_step;
    logic signed [WORD_BITS-1:0] y_step;
    logic signed [WORD_BITS-1:0] c_real;
    logic signed [WORD_BITS-1:0] c_imag;
  } coord_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP_MUL,
    ST_MAP_ADD,
    ST_SQUARE,
    ST_TEST,
    ST_DIVIDE
  } ctrl_state_t;

  typedef struct packed {
    logic take_in;
    logic map_mul;
    logic map_add;
    logic square;
    logic update;
    logic div_init;
    logic div_step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic limit_hit;
    logic escaped;
    logic div_done;
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  localparam rgb_t PALETTE [PALETTE_ENTRIES] = '{
    '{8'd10,  8'd15,  8'd20},  '{8'd20,  8'd30,  8'd40},  '{8'd30,  8'd45,  8'd60},
    '{8'd40,  8'd60,  8'd80},  '{8'd50,  8'd75,  8'd100}, '{8'd60,  8'd90,  8'd120},
    '{8'd70,  8'd105, 8'd140}, '{8'd80,  8'd120, 8'd160}, '{8'd90,  8'd135, 8'd180},
    '{8'd100, 8'd150, 8'd200}, '{8'd110, 8'd165, 8'd220}, '{8'd120, 8'd180, 8'd240},
    '{8'd130, 8'd195, 8'd255}, '{8'd140, 8'd210, 8'd255}, '{8'd150, 8'd225, 8'd255},
    '{8'd160, 8'd240, 8'd255}, '{8'd170, 8'd255, 8'd255}, '{8'd200, 8'd255, 8'd255},
    '{8'd230, 8'd255, 8'd255}, '{8'd255, 8'd255, 8'd255}, '{8'd220, 8'd220, 8'd220},
    '{8'd200, 8'd200, 8'd200}, '{8'd180, 8'd180, 8'd180}, '{8'd150, 8'd150, 8'd150},
    '{8'd120, 8'd120, 8'd120}, '{8'd90,  8'd90,  8'd90},  '{8'd50,  8'd75,  8'd100}
  };

  function automatic rgb_t palette_rgb(input logic [LAYER_BITS-1:0] idx);
    rgb_t c;
    c = PALETTE[LAYER_MAX];
    if (int'(idx) < PALETTE_ENTRIES) begin
      c = PALETTE[idx];
    end
    return c;
  endfunction

  function automatic logic signed [WORD_BITS-1:0] sat_word(
      input logic signed [PROD_BITS-1:0] v);
    logic signed [PROD_BITS-1:0] hi;
    logic signed [PROD_BITS-1:0] lo;
    logic signed [WORD_BITS-1:0] res;
    hi = PROD_BITS'({1'b0, {(WORD_BITS-1){1'b1}}});
    lo = -hi - PROD_BITS'(1);
    if (v > hi) begin
      res = {1'b0, {(WORD_BITS-1){1'b1}}};
    end else if (v < lo) begin
      res = {1'b1, {(WORD_BITS-1){1'b0}}};
    end else begin
      res = v[WORD_BITS-1:0];
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/jetp_cfg.sv =====
// ----------------------------------------------------------------------------
// jetp_cfg
// Configuration register file: origin, step, Julia constant, iteration
// limit and layer span, written through the configuration channel.
// ----------------------------------------------------------------------------
module jetp_cfg #(
  parameter int ITER_BITS = jetp_pkg::ITER_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [jetp_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [jetp_pkg::WORD_BITS-1:0]        cfg_data,
  output jetp_pkg::coord_cfg_t                  coord_cfg,
  output logic [ITER_BITS-1:0]                  iter_limit,
  output logic [ITER_BITS-1:0]                  layer_span
);
  import jetp_pkg::*;

  cfg_reg_t idx;

  assign cfg_ready = 1'b1;
  assign idx       = cfg_reg_t'(cfg_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      coord_cfg.left_origin <= LEFT_ORIGIN_RST;
      coord_cfg.top_origin  <= TOP_ORIGIN_RST;
      coord_cfg.x_step      <= X_STEP_RST;
      coord_cfg.y_step      <= Y_STEP_RST;
      coord_cfg.c_real      <= C_REAL_RST;
      coord_cfg.c_imag      <= C_IMAG_RST;
      iter_limit            <= ITER_BITS'(ITER_LIMIT_RST);
      layer_span            <= ITER_BITS'(LAYER_SPAN_RST);
    end else if (cfg_valid && cfg_ready) begin
      unique case (idx)
        REG_LEFT_ORIGIN: coord_cfg.left_origin <= cfg_data;
        REG_TOP_ORIGIN:  coord_cfg.top_origin  <= cfg_data;
        REG_X_STEP:      coord_cfg.x_step      <= cfg_data;
        REG_Y_STEP:      coord_cfg.y_step      <= cfg_data;
        REG_C_REAL:      coord_cfg.c_real      <= cfg_data;
        REG_C_IMAG:      coord_cfg.c_imag      <= cfg_data;
        REG_ITER_LIMIT:  iter_limit            <= cfg_data[ITER_BITS-1:0];
        REG_LAYER_SPAN:  layer_span            <= cfg_data[ITER_BITS-1:0];
      endcase
    end
  end

endmodule

// ===== hw/rtl/jetp_ctrl.sv =====
// ----------------------------------------------------------------------------
// jetp_ctrl
// Sequencer: accepts a request, steps the datapath through coordinate
// mapping, the square/update iteration loop and the layer division, then
// hands the result to the output register.
// ----------------------------------------------------------------------------
module jetp_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  jetp_pkg::dp_status_t   status,
  output jetp_pkg::dp_cmd_t      cmd
);
  import jetp_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_MAP_MUL;
      end
      ST_MAP_MUL: state_next = ST_MAP_ADD;
      ST_MAP_ADD: state_next = ST_SQUARE;
      ST_SQUARE:  state_next = ST_TEST;
      ST_TEST: begin
        if (status.limit_hit || status.escaped) begin
          state_next = ST_DIVIDE;
        end else begin
          state_next = ST_SQUARE;
        end
      end
      ST_DIVIDE: begin
        if (status.div_done && status.out_free) state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.take_in = in_valid;
      end
      ST_MAP_MUL: cmd.map_mul = 1'b1;
      ST_MAP_ADD: cmd.map_add = 1'b1;
      ST_SQUARE:  cmd.square  = 1'b1;
      ST_TEST: begin
        if (status.limit_hit || status.escaped) begin
          cmd.div_init = 1'b1;
        end else begin
          cmd.update = 1'b1;
        end
      end
      ST_DIVIDE: begin
        if (!status.div_done) begin
          cmd.div_step = 1'b1;
        end else if (status.out_free) begin
          cmd.load_out = 1'b1;
        end
      end
    endcase
  end

endmodule

// ===== hw/rtl/jetp_dp.sv =====
// ----------------------------------------------------------------------------
// jetp_dp
// Datapath: pixel-to-plane mapping, shared squaring multipliers, escape
// test, saturating z update, iteration counter, subtract-based layer
// divider and the result register.
// ----------------------------------------------------------------------------
module jetp_dp #(
  parameter int COORD_BITS = jetp_pkg::COORD_BITS_DEF,
  parameter int ITER_BITS  = jetp_pkg::ITER_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  jetp_pkg::dp_cmd_t                 cmd,
  output jetp_pkg::dp_status_t              status,
  input  jetp_pkg::coord_cfg_t              coord_cfg,
  input  logic [ITER_BITS-1:0]              iter_limit,
  input  logic [ITER_BITS-1:0]              layer_span,
  input  logic [COORD_BITS-1:0]             pixel_x,
  input  logic [COORD_BITS-1:0]             pixel_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [COORD_BITS-1:0]             out_x,
  output logic [COORD_BITS-1:0]             out_y,
  output logic [ITER_BITS-1:0]              iter_count,
  output logic [jetp_pkg::LAYER_BITS-1:0]   layer,
  output logic [7:0]                        red,
  output logic [7:0]                        green,
  output logic [7:0]                        blue
);
  import jetp_pkg::*;

  localparam int MAP_BITS = COORD_BITS + 1 + WORD_BITS;

  logic [COORD_BITS-1:0]        px;
  logic [COORD_BITS-1:0]        py;
  logic signed [MAP_BITS-1:0]   prod_x;
  logic signed [MAP_BITS-1:0]   prod_y;
  logic signed [WORD_BITS-1:0]  zr;
  logic signed [WORD_BITS-1:0]  zi;
  logic signed [PROD_BITS-1:0]  rr;
  logic signed [PROD_BITS-1:0]  ii;
  logic signed [PROD_BITS-1:0]  ri;
  logic [ITER_BITS-1:0]         count;
  logic [ITER_BITS-1:0]         rem;
  logic [LAYER_BITS-1:0]        lay;

  logic signed [PROD_BITS-1:0]  map_r;
  logic signed [PROD_BITS-1:0]  map_i;
  logic signed [PROD_BITS-1:0]  upd_r;
  logic signed [PROD_BITS-1:0]  upd_i;
  logic [PROD_BITS:0]           mag;
  rgb_t                         rgb;

  assign map_r = PROD_BITS'(prod_x) + PROD_BITS'(coord_cfg.left_origin);
  assign map_i = PROD_BITS'(prod_y) + PROD_BITS'(coord_cfg.top_origin);
  // arithmetic shift gives floor
  assign upd_r = ((rr - ii) >>> FRAC_BITS) + PROD_BITS'(coord_cfg.c_real);
  assign upd_i = (ri >>> (FRAC_BITS - 1)) + PROD_BITS'(coord_cfg.c_imag);
  assign mag   = {1'b0, rr} + {1'b0, ii};
  assign rgb   = palette_rgb(lay);

  assign status.limit_hit = (count >= iter_limit);
  assign status.escaped   = (mag >= ESC_LIMIT);
  assign status.div_done  = (int'(lay) == LAYER_MAX) || (rem < layer_span);
  assign status.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      px <= pixel_x;
      py <= pixel_y;
    end
    if (cmd.map_mul) begin
      prod_x <= $signed({1'b0, px}) * coord_cfg.x_step;
      prod_y <= $signed({1'b0, py}) * coord_cfg.y_step;
    end
    if (cmd.map_add) begin
      zr    <= sat_word(map_r);
      zi    <= sat_word(map_i);
      count <= '0;
    end
    if (cmd.square) begin
      rr <= zr * zr;
      ii <= zi * zi;
      ri <= zr * zi;
    end
    if (cmd.update) begin
      zr    <= sat_word(upd_r);
      zi    <= sat_word(upd_i);
      count <= count + ITER_BITS'(1);
    end
    if (cmd.div_init) begin
      rem <= count;
      lay <= (layer_span == '0) ? LAYER_BITS'(LAYER_MAX) : '0;
    end
    if (cmd.div_step) begin
      rem <= rem - layer_span;
      lay <= lay + LAYER_BITS'(1);
    end
    if (cmd.load_out) begin
      out_x      <= px;
      out_y      <= py;
      iter_count <= count;
      layer      <= lay;
      red        <= rgb.r;
      green      <= rgb.g;
      blue       <= rgb.b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== hw/rtl/julia_escape_time_pixel_top.sv =====
// ----------------------------------------------------------------------------
// julia_escape_time_pixel_top
// Julia-set escape-time evaluator for one pixel: maps the pixel to the
// complex plane, iterates z = z^2 + c in Q4.28 and returns count, palette
// layer and RGB colour.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------------
//   in       | in_valid / in_ready  | pixel_x, pixel_y
//   out      | out_valid / out_ready| out_x, out_y, iter_count, layer, rgb
//   cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data (always ready)
//
// One request at a time: accept, mapping (multiply, then add), then per
// iteration a square on the shared squaring multipliers and an escape test
// with update, a final square and test, one subtract per palette layer in
// the divider and a load of the result. A new request is accepted while the
// previous result waits; a stalled output holds the divider. Synchronous
// reset restores register defaults.
// ----------------------------------------------------------------------------
module julia_escape_time_pixel_top #(
  parameter int COORD_BITS = jetp_pkg::COORD_BITS_DEF,
  parameter int ITER_BITS  = jetp_pkg::ITER_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [jetp_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [jetp_pkg::WORD_BITS-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [COORD_BITS-1:0]             pixel_x,
  input  logic [COORD_BITS-1:0]             pixel_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [COORD_BITS-1:0]             out_x,
  output logic [COORD_BITS-1:0]             out_y,
  output logic [ITER_BITS-1:0]              iter_count,
  output logic [jetp_pkg::LAYER_BITS-1:0]   layer,
  output logic [7:0]                        red,
  output logic [7:0]                        green,
  output logic [7:0]                        blue
);
  import jetp_pkg::*;

  coord_cfg_t           coord_cfg;
  logic [ITER_BITS-1:0] iter_limit;
  logic [ITER_BITS-1:0] layer_span;
  dp_cmd_t              cmd;
  dp_status_t           status;

  jetp_cfg #(
    .ITER_BITS (ITER_BITS)
  ) u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .coord_cfg  (coord_cfg),
    .iter_limit (iter_limit),
    .layer_span (layer_span)
  );

  jetp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  jetp_dp #(
    .COORD_BITS (COORD_BITS),
    .ITER_BITS  (ITER_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .coord_cfg  (coord_cfg),
    .iter_limit (iter_limit),
    .layer_span (layer_span),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_x      (out_x),
    .out_y      (out_y),
    .iter_count (iter_count),
    .layer      (layer),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

endmodule
